[rtl/core/olas_pkg.sv]
// ----------------------------------------------------------------------------
// olas_pkg: overstrike line assembler shared definitions
// Widths, character codes, payload types, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package olas_pkg;

  localparam int LINE_CELLS_DEF = 1024;
  localparam int TAB_W          = 7;
  localparam int LEN_W          = 11;
  localparam int COL_W          = 10;

  localparam logic [TAB_W-1:0] TAB_RESET = 7'd8;

  localparam logic [7:0] CH_BS         = 8'd8;
  localparam logic [7:0] CH_TAB        = 8'd9;
  localparam logic [7:0] CH_NL         = 8'd10;
  localparam logic [7:0] CH_CR         = 8'd13;
  localparam logic [7:0] CH_SPACE      = 8'd32;
  localparam logic [7:0] CH_UNDERSCORE = 8'd95;

  localparam logic [1:0] ATTR_BOLD  = 2'b01;
  localparam logic [1:0] ATTR_ULINE = 2'b10;

  typedef struct packed {
    logic             op;
    logic [7:0]       char_code;
    logic [COL_W-1:0] column;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       cell_char;
    logic             bold;
    logic             underline;
    logic [LEN_W-1:0] line_length;
    logic [LEN_W-1:0] cursor_pos;
    logic             line_done;
    logic             too_long;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHAR,
    ST_DIV,
    ST_TCHK,
    ST_FILL,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    CLS_READ,
    CLS_TAB,
    CLS_CHAR,
    CLS_MOVE
  } item_cls_t;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic tab_check;
    logic fill_step;
    logic char_write;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    item_cls_t cls;
    logic      at_end;
    logic      div_last;
    logic      tab_over;
    logic      fill_last;
  } dp_sts_t;

endpackage

[rtl/core/olas_if.sv]
// ----------------------------------------------------------------------------
// olas_if: overstrike line assembler channel interfaces
// Valid/ready channels for input words, result words and configuration.
// ----------------------------------------------------------------------------
interface olas_in_if;
  logic               valid;
  logic               ready;
  olas_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface olas_out_if;
  logic                valid;
  logic                ready;
  olas_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface olas_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [olas_pkg::TAB_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/olas_ram.sv]
// ----------------------------------------------------------------------------
// olas_ram: generic simple dual-port RAM
// One write port, one read port with enable and registered read data.
// ----------------------------------------------------------------------------
module olas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = olas_pkg::LINE_CELLS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/olas_ctrl.sv]
// ----------------------------------------------------------------------------
// olas_ctrl: overstrike line assembler controller
// Sequences one word at a time through decode, remainder, tab fill, cell
// update and result hand-off; owns the result valid flag.
// ----------------------------------------------------------------------------
module olas_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  olas_pkg::dp_sts_t sts,
  output olas_pkg::dp_cmd_t cmd
);

  olas_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= olas_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      olas_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          case (sts.cls)
            olas_pkg::CLS_TAB:  state_nxt = olas_pkg::ST_DIV;
            olas_pkg::CLS_CHAR: state_nxt = sts.at_end ? olas_pkg::ST_FIN : olas_pkg::ST_CHAR;
            default:            state_nxt = olas_pkg::ST_FIN;
          endcase
        end
      end
      olas_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = olas_pkg::ST_TCHK;
        end
      end
      olas_pkg::ST_TCHK: begin
        cmd.tab_check = 1'b1;
        state_nxt     = sts.tab_over ? olas_pkg::ST_FIN : olas_pkg::ST_FILL;
      end
      olas_pkg::ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.fill_last) begin
          state_nxt = olas_pkg::ST_FIN;
        end
      end
      olas_pkg::ST_CHAR: begin
        cmd.char_write = 1'b1;
        state_nxt      = olas_pkg::ST_FIN;
      end
      olas_pkg::ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = olas_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = olas_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[rtl/core/olas_dpath.sv]
// ----------------------------------------------------------------------------
// olas_dpath: overstrike line assembler datapath
// Cursor, length and line state, bit-serial tab remainder, cell stores
// and the result register.
// ----------------------------------------------------------------------------
module olas_dpath #(
  parameter int LINE_CELLS = olas_pkg::LINE_CELLS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  olas_pkg::dp_cmd_t          cmd,
  output olas_pkg::dp_sts_t          sts,
  input  olas_pkg::in_item_t         in_data,
  input  logic                       cfg_valid,
  input  logic [olas_pkg::TAB_W-1:0] cfg_data,
  output olas_pkg::out_item_t        out_data
);

  localparam int CW  = $clog2(LINE_CELLS + 1);
  localparam int AW  = $clog2(LINE_CELLS);
  localparam int EW  = (CW > olas_pkg::LEN_W) ? CW : olas_pkg::LEN_W;
  localparam int TW  = EW + 1;
  localparam int CNW = $clog2(CW);
  localparam int TBW = olas_pkg::TAB_W;
  localparam logic [CW-1:0] CELLS_C = CW'(LINE_CELLS);

  logic [CW-1:0]       cursor_r, cursor_nxt;
  logic [CW-1:0]       max_r, max_nxt;
  logic                closed_r, closed_nxt;
  logic [TBW-1:0]      tab_size_r, tab_size_nxt;
  logic [7:0]          ch_r;
  logic                is_read_r;
  logic                rd_ok_r;
  logic                done_r, done_nxt;
  logic                drop_r, drop_nxt;
  logic [CW-1:0]       dvd_r, dvd_nxt;
  logic [TBW-1:0]      rem_r, rem_nxt;
  logic [CNW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]       fill_end_r;
  olas_pkg::out_item_t out_r, out_nxt;

  logic [TBW-1:0] ts_eff;
  logic [CW-1:0]  base_cur;
  logic [CW-1:0]  base_max;
  logic [EW-1:0]  col_x;
  logic [EW-1:0]  cur_x;
  logic [EW-1:0]  bmax_x;
  logic [EW-1:0]  wcur_x;
  logic [EW-1:0]  len_x;
  logic [EW-1:0]  pos_x;
  logic [TBW:0]   div_t;
  logic [TBW:0]   div_sub;
  logic [TBW-1:0] tab_gap;
  logic [TW-1:0]  tab_end;
  logic [CW-1:0]  cur_inc;
  logic           cell_valid;
  logic [7:0]     old_c;
  logic [1:0]     old_a;
  logic [7:0]     new_c;
  logic [1:0]     new_a;

  logic [AW-1:0]  raddr;
  logic [AW-1:0]  waddr;
  logic           c_we;
  logic           a_we;
  logic [7:0]     c_wdata;
  logic [1:0]     a_wdata;
  logic [7:0]     rd_char;
  logic [1:0]     rd_attr;

  olas_ram #(.WIDTH(8), .DEPTH(LINE_CELLS)) u_char_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (waddr),
    .wdata (c_wdata),
    .re    (cmd.accept),
    .raddr (raddr),
    .rdata (rd_char)
  );

  olas_ram #(.WIDTH(2), .DEPTH(LINE_CELLS)) u_attr_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (waddr),
    .wdata (a_wdata),
    .re    (cmd.accept),
    .raddr (raddr),
    .rdata (rd_attr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r   <= '0;
      max_r      <= '0;
      closed_r   <= 1'b1;
      tab_size_r <= olas_pkg::TAB_RESET;
    end else begin
      cursor_r   <= cursor_nxt;
      max_r      <= max_nxt;
      closed_r   <= closed_nxt;
      tab_size_r <= tab_size_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ch_r      <= in_data.char_code;
      is_read_r <= in_data.op;
      rd_ok_r   <= col_x < bmax_x;
    end
    if (cmd.tab_check) begin
      fill_end_r <= tab_end[CW-1:0];
    end
    done_r <= done_nxt;
    drop_r <= drop_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    out_r  <= out_nxt;
  end

  // decode and addressing
  always_comb begin
    ts_eff   = (tab_size_r == '0) ? TBW'(1) : tab_size_r;
    base_cur = closed_r ? '0 : cursor_r;
    base_max = closed_r ? '0 : max_r;
    col_x    = EW'(in_data.column);
    cur_x    = EW'(base_cur);
    bmax_x   = EW'(max_r);
    wcur_x   = EW'(cursor_r);
    raddr    = in_data.op ? col_x[AW-1:0] : cur_x[AW-1:0];
    waddr    = wcur_x[AW-1:0];

    if (in_data.op) begin
      sts.cls = olas_pkg::CLS_READ;
    end else if (in_data.char_code == olas_pkg::CH_TAB) begin
      sts.cls = olas_pkg::CLS_TAB;
    end else if (in_data.char_code >= olas_pkg::CH_SPACE) begin
      sts.cls = olas_pkg::CLS_CHAR;
    end else begin
      sts.cls = olas_pkg::CLS_MOVE;
    end
    sts.at_end = base_cur >= CELLS_C;

    div_t        = {rem_r, dvd_r[CW-1]};
    div_sub      = div_t - {1'b0, ts_eff};
    sts.div_last = cnt_r == CNW'(CW - 1);

    tab_gap      = ts_eff - rem_r;
    tab_end      = TW'(cursor_r) + TW'(tab_gap);
    sts.tab_over = tab_end > TW'(LINE_CELLS);

    cur_inc       = cursor_r + CW'(1);
    sts.fill_last = cur_inc == fill_end_r;
  end

  // overstrike merge
  always_comb begin
    cell_valid = cursor_r < max_r;
    old_c      = cell_valid ? rd_char : '0;
    old_a      = cell_valid ? rd_attr : '0;
    new_c      = old_c;
    new_a      = old_a;
    if (old_c == '0) begin
      new_c = ch_r;
    end else if (old_c == ch_r) begin
      new_a = old_a | olas_pkg::ATTR_BOLD;
    end else if (old_c == olas_pkg::CH_UNDERSCORE) begin
      new_a = old_a | olas_pkg::ATTR_ULINE;
      new_c = ch_r;
    end else if (ch_r == olas_pkg::CH_UNDERSCORE) begin
      new_a = old_a | olas_pkg::ATTR_ULINE;
    end

    c_we    = cmd.fill_step | cmd.char_write;
    a_we    = cmd.char_write | (cmd.fill_step & ~cell_valid);
    c_wdata = cmd.fill_step ? olas_pkg::CH_SPACE : new_c;
    a_wdata = cmd.fill_step ? 2'b00 : new_a;
  end

  // state update
  always_comb begin
    cursor_nxt   = cursor_r;
    max_nxt      = max_r;
    closed_nxt   = closed_r;
    tab_size_nxt = tab_size_r;
    done_nxt     = done_r;
    drop_nxt     = drop_r;
    dvd_nxt      = dvd_r;
    rem_nxt      = rem_r;
    cnt_nxt      = cnt_r;

    if (cfg_valid) begin
      tab_size_nxt = cfg_data;
    end

    if (cmd.accept) begin
      done_nxt = 1'b0;
      drop_nxt = 1'b0;
      if (!in_data.op) begin
        cursor_nxt = base_cur;
        max_nxt    = base_max;
        closed_nxt = 1'b0;
        dvd_nxt    = base_cur;
        rem_nxt    = '0;
        cnt_nxt    = '0;
        case (in_data.char_code)
          olas_pkg::CH_BS: begin
            if (base_cur != '0) begin
              cursor_nxt = base_cur - CW'(1);
            end
          end
          olas_pkg::CH_CR: begin
            cursor_nxt = '0;
          end
          olas_pkg::CH_NL: begin
            closed_nxt = 1'b1;
            done_nxt   = 1'b1;
          end
          default: begin
            drop_nxt = (in_data.char_code >= olas_pkg::CH_SPACE) && sts.at_end;
          end
        endcase
      end
    end

    if (cmd.div_step) begin
      rem_nxt = div_sub[TBW] ? div_t[TBW-1:0] : div_sub[TBW-1:0];
      dvd_nxt = {dvd_r[CW-2:0], 1'b0};
      cnt_nxt = cnt_r + CNW'(1);
    end

    if (cmd.tab_check) begin
      drop_nxt = sts.tab_over;
    end

    if (cmd.fill_step) begin
      cursor_nxt = cur_inc;
      if (sts.fill_last && (fill_end_r > max_r)) begin
        max_nxt = fill_end_r;
      end
    end

    if (cmd.char_write) begin
      cursor_nxt = cur_inc;
      if (cur_inc > max_r) begin
        max_nxt = cur_inc;
      end
    end
  end

  // result register
  always_comb begin
    len_x   = EW'(max_r);
    pos_x   = EW'(cursor_r);
    out_nxt = out_r;
    if (cmd.load_out) begin
      out_nxt.cell_char   = (is_read_r && rd_ok_r) ? rd_char : '0;
      out_nxt.bold        = is_read_r & rd_ok_r & rd_attr[0];
      out_nxt.underline   = is_read_r & rd_ok_r & rd_attr[1];
      out_nxt.line_length = len_x[olas_pkg::LEN_W-1:0];
      out_nxt.cursor_pos  = pos_x[olas_pkg::LEN_W-1:0];
      out_nxt.line_done   = done_r;
      out_nxt.too_long    = drop_r;
    end
  end

  assign out_data = out_r;

endmodule

[rtl/core/overstrike_line_assembler_core.sv]
// ----------------------------------------------------------------------------
// overstrike_line_assembler_core: overstrike line assembler
// Builds one text line from a byte stream with tab, backspace, return,
// newline, bold and underline overstrike, and reads back stored cells.
// ----------------------------------------------------------------------------
// One word is in flight at a time. A read, backspace, return, newline,
// dropped control byte or printable byte dropped at the end of the line
// goes from acceptance to hand-off; a stored printable byte reads the
// RAM at acceptance, then does a read-modify-write. A tab has acceptance,
// a bit-serial remainder of the cursor by the tab size, one check, one
// fill step per space written at the shared RAM write address, then the
// hand-off; a dropped tab writes no spaces. A finished result sits in the
// output register, so the next word is taken while it waits.
// There is no clearing pass: the first byte after a closed line zeroes
// the length, and cells at or above the length read as empty.
// ----------------------------------------------------------------------------
module overstrike_line_assembler_core #(
  parameter int LINE_CELLS = olas_pkg::LINE_CELLS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  olas_in_if.sink    in_ch,
  olas_out_if.source out_ch,
  olas_cfg_if.sink   cfg_ch
);

  olas_pkg::dp_cmd_t cmd;
  olas_pkg::dp_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  olas_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  olas_dpath #(.LINE_CELLS(LINE_CELLS)) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_ch.data),
    .cfg_valid (cfg_ch.valid),
    .cfg_data  (cfg_ch.data),
    .out_data  (out_ch.data)
  );

endmodule
